@@ rtl/rlb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_pkg
// shared types, constants and the gamma expansion table of the lab converter
// ----------------------------------------------------------------------------
package rlb_pkg;

  typedef logic [19:0] lin_t;
  typedef logic [21:0] t_t;
  typedef logic [20:0] root_t;
  typedef logic [19:0] coef_t;
  typedef lin_t gamma_lut_t [256];
  typedef coef_t mat_t [3][3];

  localparam int NLANE = 3;
  localparam int ROOT_BITS = 21;

  // srgb to xyz matrix in q20
  localparam mat_t MAT = '{
    '{20'd432488, 20'd374950, 20'd189187},
    '{20'd223002, 20'd749900, 20'd75675},
    '{20'd20273,  20'd124983, 20'd996385}
  };

  // white point reciprocals, floor(10000 * 2^32 / d)
  localparam logic [13:0] WP_X = 14'd9515;
  localparam logic [13:0] WP_Z = 14'd10886;
  localparam logic [32:0] KX = 33'((64'd10000 << 32) / 64'd9515);
  localparam logic [32:0] KZ = 33'((64'd10000 << 32) / 64'd10886);

  // linear branch of f(), t * 7.787 exact by ceil reciprocal
  localparam logic [21:0] F_THRESHOLD = 22'd9286;
  localparam logic [21:0] F_OFFSET = 22'd144632;
  localparam logic [27:0] KLOW = 28'((64'd7787 * (64'd1 << 24) + 64'd999) / 64'd1000);

  // floor division by the bin step through an offset and a reciprocal
  localparam int QUANT_STEP = 15;
  localparam logic [12:0] BIN_BIAS = 13'd137;
  localparam logic [12:0] BIN_OFS = 13'(137 * QUANT_STEP);
  localparam logic [12:0] KBIN = 13'((65536 + QUANT_STEP - 1) / QUANT_STEP);
  localparam logic [13:0] HALF_STEP = 14'(QUANT_STEP / 2);

  function automatic longint unsigned p5_q20(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 20;
    end
    return p;
  endfunction

  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    longint unsigned u, s, r, cand;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        lut[c] = lin_t'((longint'(c) * 104857600) / 330752);
      end else begin
        u = (longint'(c) * 4096000 + 57671680) / 1055;
        s = (u * u) >> 20;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
          cand = r | (longint'(1) << b);
          if (p5_q20(cand) <= s) r = cand;
        end
        lut[c] = lin_t'((s * r) >> 20);
      end
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

@@ rtl/rgb_to_lab_bin.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_lab_bin
// srgb pixel to cielab values or quantized lab bins
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with in_red, in_green, in_blue
// output channel: out_valid / out_stall with lightness, a, b and bin index
// config: cfg_we writes cfg_wdata into the raw mode bit (1 = truncated lab)
// throughput: one word per cycle while the output is not stalled; set by the
// 21-stage cube root pipeline that produces one root bit per stage
// the whole pipeline advances together; a stalled output word freezes
// every stage and raises in_stall in the same cycle, nothing is dropped
// reset clears all valid bits and selects quantized bins
// ----------------------------------------------------------------------------
module rgb_to_lab_bin import rlb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_lightness,
  output logic signed [7:0] out_green_red,
  output logic signed [7:0] out_blue_yellow,
  output logic [10:0]       out_bin_index,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  logic  en;
  logic  raw_mode_r;
  logic  xyz_v, cb_v;
  t_t    t_in [NLANE];
  t_t    t_cb [NLANE];
  root_t r_cb [NLANE];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
    end else if (cfg_we) begin
      raw_mode_r <= cfg_wdata;
    end
  end

  rlb_xyz u_xyz (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .out_v (xyz_v),
    .t_x   (t_in[0]),
    .t_y   (t_in[1]),
    .t_z   (t_in[2])
  );

  rlb_cbrt u_cbrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (xyz_v),
    .in_t  (t_in),
    .out_v (cb_v),
    .out_t (t_cb),
    .out_r (r_cb)
  );

  rlb_lab u_lab (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .raw_mode    (raw_mode_r),
    .in_v        (cb_v),
    .in_t        (t_cb),
    .in_r        (r_cb),
    .out_v       (out_valid),
    .lightness   (out_lightness),
    .green_red   (out_green_red),
    .blue_yellow (out_blue_yellow),
    .bin_index   (out_bin_index)
  );

endmodule

@@ rtl/rlb_xyz.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_xyz
// gamma expansion, rgb to xyz matrix and white point scaling, five stages
// ----------------------------------------------------------------------------
module rlb_xyz import rlb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_v,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_v,
  output t_t         t_x,
  output t_t         t_y,
  output t_t         t_z
);

  logic [4:0]  v_r;
  lin_t        lin_r [3];
  logic [39:0] prod_r [3][3];
  t_t          xyz_r [3];
  t_t          x4_r, y4_r, z4_r;
  logic [22:0] qx_r, qz_r;
  t_t          tx_r, ty_r, tz_r;

  logic [41:0] sum [3];
  logic [54:0] px, pz;

  function automatic t_t wp_fix(input t_t x, input logic [22:0] q0, input logic [13:0] d);
    logic [36:0] n, m, rem;
    logic [23:0] q;
    n = 37'(x) * 37'd10000;
    m = 37'(q0) * 37'(d);
    rem = n - m;
    q = (rem >= 37'(d)) ? 24'(q0) + 24'd1 : 24'(q0);
    return (q > 24'h3FFFFF) ? 22'h3FFFFF : q[21:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 42'(prod_r[i][0]) + 42'(prod_r[i][1]) + 42'(prod_r[i][2]);
    end
    px = 55'(xyz_r[0]) * 55'(KX);
    pz = 55'(xyz_r[2]) * 55'(KZ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= GAMMA_LUT[red];
      lin_r[1] <= GAMMA_LUT[green];
      lin_r[2] <= GAMMA_LUT[blue];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= 40'(lin_r[j]) * 40'(MAT[i][j]);
        end
        xyz_r[i] <= sum[i][41:20];
      end
      x4_r <= xyz_r[0];
      y4_r <= xyz_r[1];
      z4_r <= xyz_r[2];
      qx_r <= px[54:32];
      qz_r <= pz[54:32];
      tx_r <= wp_fix(x4_r, qx_r, WP_X);
      ty_r <= y4_r;
      tz_r <= wp_fix(z4_r, qz_r, WP_Z);
    end
  end

  assign out_v = v_r[4];
  assign t_x = tx_r;
  assign t_y = ty_r;
  assign t_z = tz_r;

endmodule

@@ rtl/rlb_cbrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_cbrt
// cube root of three q20 lanes, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module rlb_cbrt import rlb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_v,
  input  t_t    in_t [NLANE],
  output logic  out_v,
  output t_t    out_t [NLANE],
  output root_t out_r [NLANE]
);

  logic        v_r  [ROOT_BITS];
  root_t       r_r  [ROOT_BITS][NLANE];
  logic [41:0] r2_r [ROOT_BITS][NLANE];
  logic [62:0] r3_r [ROOT_BITS][NLANE];
  t_t          t_r  [ROOT_BITS][NLANE];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
    localparam int KB = ROOT_BITS - 1 - j;
    logic        pv;
    root_t       pr  [NLANE];
    logic [41:0] pr2 [NLANE];
    logic [62:0] pr3 [NLANE];
    t_t          pt  [NLANE];
    logic [63:0] c2  [NLANE];
    logic [63:0] c3  [NLANE];
    logic        ok  [NLANE];

    if (j == 0) begin : g_first
      assign pv = in_v;
      for (genvar l = 0; l < NLANE; l++) begin : g_l
        assign pr[l]  = '0;
        assign pr2[l] = '0;
        assign pr3[l] = '0;
        assign pt[l]  = in_t[l];
      end
    end else begin : g_next
      assign pv = v_r[j-1];
      for (genvar l = 0; l < NLANE; l++) begin : g_l
        assign pr[l]  = r_r[j-1][l];
        assign pr2[l] = r2_r[j-1][l];
        assign pr3[l] = r3_r[j-1][l];
        assign pt[l]  = t_r[j-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        c2[l] = 64'(pr2[l]) + (64'(pr[l]) << (KB + 1)) + (64'd1 << (2 * KB));
        c3[l] = 64'(pr3[l]) + ((64'(pr2[l]) * 64'd3) << KB)
              + ((64'(pr[l]) * 64'd3) << (2 * KB)) + (64'd1 << (3 * KB));
        ok[l] = c3[l] <= {2'b00, pt[l], 40'd0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NLANE; l++) begin
          r_r[j][l]  <= ok[l] ? (pr[l] | (root_t'(1) << KB)) : pr[l];
          r2_r[j][l] <= ok[l] ? c2[l][41:0] : pr2[l];
          r3_r[j][l] <= ok[l] ? c3[l][62:0] : pr3[l];
          t_r[j][l]  <= pt[l];
        end
      end
    end
  end

  assign out_v = v_r[ROOT_BITS-1];
  for (genvar l = 0; l < NLANE; l++) begin : g_out
    assign out_t[l] = t_r[ROOT_BITS-1][l];
    assign out_r[l] = r_r[ROOT_BITS-1][l];
  end

endmodule

@@ rtl/rlb_lab.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_lab
// f() select, lab arithmetic, binning or truncation and the output register
// ----------------------------------------------------------------------------
module rlb_lab import rlb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              raw_mode,
  input  logic              in_v,
  input  t_t                in_t [NLANE],
  input  root_t             in_r [NLANE],
  output logic              out_v,
  output logic [6:0]        lightness,
  output logic signed [7:0] green_red,
  output logic signed [7:0] blue_yellow,
  output logic [10:0]       bin_index
);

  logic [2:0]         v_r;
  t_t                 f_r [NLANE];
  logic signed [33:0] lab_r [3];
  logic signed [13:0] tr_r [3];
  logic signed [10:0] bin_r [3];
  logic               v_out_r;
  logic [6:0]         l_out_r;
  logic signed [7:0]  a_out_r, b_out_r;
  logic [10:0]        idx_out_r;

  logic signed [33:0] fs [NLANE];
  logic signed [13:0] fl [3];
  logic signed [13:0] tr [3];
  logic signed [10:0] bn [3];
  logic [41:0]        low [NLANE];
  logic [6:0]         l_nxt;
  logic signed [7:0]  a_nxt, b_nxt;
  logic [10:0]        idx_nxt;
  logic [3:0]         lb, ab, bb;

  function automatic logic signed [10:0] bin15(input logic signed [13:0] s);
    logic [12:0] w;
    logic [25:0] p;
    w = 13'(s) + BIN_OFS;
    p = 26'(w) * 26'(KBIN);
    return $signed(11'(p[25:16])) - $signed(11'(BIN_BIAS));
  endfunction

  function automatic logic signed [7:0] sat8(input logic signed [13:0] s);
    if (s < -14'sd128) return -8'sd128;
    if (s > 14'sd127) return 8'sd127;
    return s[7:0];
  endfunction

  function automatic logic [3:0] clampb(input logic signed [10:0] s,
                                        input logic signed [10:0] hi);
    if (s < 11'sd0) return 4'd0;
    if (s > hi) return hi[3:0];
    return s[3:0];
  endfunction

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      low[l] = 42'(in_t[l][13:0]) * 42'(KLOW);
      fs[l] = $signed(34'(f_r[l]));
    end
    for (int i = 0; i < 3; i++) begin
      fl[i] = lab_r[i][33:20];
      tr[i] = fl[i] + 14'((lab_r[i][33] && (lab_r[i][19:0] != '0)) ? 1 : 0);
    end
    bn[0] = bin15(fl[0]);
    bn[1] = bin15(fl[1] + $signed(HALF_STEP)) + 11'sd6;
    bn[2] = bin15(fl[2] + $signed(HALF_STEP)) + 11'sd7;

    lb = clampb(bin_r[0], 11'sd6);
    ab = clampb(bin_r[1], 11'sd12);
    bb = clampb(bin_r[2], 11'sd13);
    if (raw_mode) begin
      l_nxt = (tr_r[0] < 14'sd0) ? 7'd0 : ((tr_r[0] > 14'sd127) ? 7'd127 : tr_r[0][6:0]);
      a_nxt = sat8(tr_r[1]);
      b_nxt = sat8(tr_r[2]);
      idx_nxt = '0;
    end else begin
      l_nxt = 7'(lb);
      a_nxt = 8'(ab);
      b_nxt = 8'(bb);
      idx_nxt = 11'(lb) * 11'd182 + 11'(ab) * 11'd14 + 11'(bb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      v_out_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
      v_out_r <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        f_r[l] <= (in_t[l] <= F_THRESHOLD) ? 22'(low[l][41:24]) + F_OFFSET : 22'(in_r[l]);
      end
      lab_r[0] <= fs[1] * 34'sd116 - 34'sd16777216;
      lab_r[1] <= (fs[0] - fs[1]) * 34'sd500;
      lab_r[2] <= (fs[1] - fs[2]) * 34'sd200;
      tr_r <= tr;
      bin_r <= bn;
      l_out_r <= l_nxt;
      a_out_r <= a_nxt;
      b_out_r <= b_nxt;
      idx_out_r <= idx_nxt;
    end
  end

  assign out_v = v_out_r;
  assign lightness = l_out_r;
  assign green_red = a_out_r;
  assign blue_yellow = b_out_r;
  assign bin_index = idx_out_r;

endmodule

@@ rtl/rlb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_checker
// port level checks of the lab converter, bound to the top level
// ----------------------------------------------------------------------------
module rlb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [6:0]        out_lightness,
  input logic signed [7:0] out_green_red,
  input logic signed [7:0] out_blue_yellow,
  input logic [10:0]       out_bin_index
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_bin_index) && $stable(out_lightness))
    else $error("output word changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output is stalled");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bin_index != 11'd0 |-> out_lightness <= 7'd6
      && out_green_red >= 8'sd0 && out_green_red <= 8'sd12
      && out_blue_yellow >= 8'sd0 && out_blue_yellow <= 8'sd13)
    else $error("bin out of range");

  a_bin_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bin_index != 11'd0 |-> out_bin_index ==
      11'(out_lightness) * 11'd182 + 11'(out_green_red) * 11'd14 + 11'(out_blue_yellow))
    else $error("bin index does not match bins");

endmodule

bind rgb_to_lab_bin rlb_checker u_rlb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_lightness   (out_lightness),
  .out_green_red   (out_green_red),
  .out_blue_yellow (out_blue_yellow),
  .out_bin_index   (out_bin_index)
);
